### hdl/fos_pkg.sv
package fos_pkg;

  // Sizing
  localparam int UNIVERSE_POINTS = 60;
  localparam int MEMBERSHIP_BITS = 16;
  localparam int MUW             = MEMBERSHIP_BITS + 1;
  localparam int DIST_W          = 9;
  localparam int LIMIT_W         = 8;
  localparam int SPAN_W          = LIMIT_W + 4;
  localparam int STEER_W         = 15;
  localparam int DIR_W           = 2;
  localparam int STEER_FRAC      = 7;
  localparam int NUM_DIST        = 4;

  // Output universe, scaled by the number of intervals
  localparam int SCALE  = UNIVERSE_POINTS - 1;
  localparam int SPAN20 = 20 * SCALE;
  localparam int SPAN30 = 30 * SCALE;

  // Steering limits in 1/128 units
  localparam int STEER_MAX = 100 * 128;
  localparam int BACK_LIM  = -70 * 128;
  localparam int LEFT_LIM  = -10 * 128;
  localparam int RIGHT_LIM = 10 * 128;

  // Configuration port
  localparam int              CFG_AW             = 3;
  localparam logic [0:0]      REG_CORRIDOR_LIMIT = 1'b0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET     = 8'd25;

  // Output set selectors
  localparam int SET_LEFT     = 0;
  localparam int SET_STRAIGHT = 1;
  localparam int SET_RIGHT    = 2;
  localparam int SET_BACK     = 3;

  typedef logic [MUW-1:0] mu_t;

  localparam mu_t MU_ONE = {1'b1, {MEMBERSHIP_BITS{1'b0}}};

  typedef struct packed {
    mu_t near_mu;
    mu_t med_mu;
    mu_t far_mu;
  } dist_mu_t;

  typedef struct packed {
    mu_t left_p;
    mu_t straight_p;
    mu_t right_p;
    mu_t back_p;
  } pref_t;

  typedef enum logic [DIR_W-1:0] {
    DIR_BACK  = 2'd0,
    DIR_LEFT  = 2'd1,
    DIR_RIGHT = 2'd2,
    DIR_FWD   = 2'd3
  } dir_t;

  typedef struct packed {
    logic signed [STEER_W-1:0] steering_value;
    dir_t                      direction_code;
    logic                      no_activation;
  } result_t;

  function automatic mu_t mu_min(mu_t a, mu_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic mu_t mu_max(mu_t a, mu_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic int univ_x(int i);
    return -100 * SCALE + 200 * i;
  endfunction

  function automatic mu_t ramp20(int off);
    return mu_t'((longint'(off) << MEMBERSHIP_BITS) / SPAN20);
  endfunction

  function automatic mu_t ramp30(int off);
    return mu_t'((longint'(off) << MEMBERSHIP_BITS) / SPAN30);
  endfunction

  // Membership of an output trapezoid at universe point i
  function automatic mu_t out_set_mu(int set_id, int i);
    int  x;
    mu_t v;
    x = univ_x(i);
    v = '0;
    case (set_id)
      SET_LEFT: begin
        if (x <= -80 * SCALE || x >= -10 * SCALE) v = '0;
        else if (x < -60 * SCALE) v = ramp20(x + 80 * SCALE);
        else if (x <= -40 * SCALE) v = MU_ONE;
        else v = ramp30(-10 * SCALE - x);
      end
      SET_STRAIGHT: begin
        if (x <= -30 * SCALE || x >= 30 * SCALE) v = '0;
        else if (x < -10 * SCALE) v = ramp20(x + 30 * SCALE);
        else if (x <= 10 * SCALE) v = MU_ONE;
        else v = ramp20(30 * SCALE - x);
      end
      SET_RIGHT: begin
        if (x <= 10 * SCALE || x >= 80 * SCALE) v = '0;
        else if (x < 40 * SCALE) v = ramp30(x - 10 * SCALE);
        else if (x <= 60 * SCALE) v = MU_ONE;
        else v = ramp20(80 * SCALE - x);
      end
      SET_BACK: begin
        if (x <= -100 * SCALE || x >= -40 * SCALE) v = '0;
        else if (x < -80 * SCALE) v = ramp20(x + 100 * SCALE);
        else if (x <= -60 * SCALE) v = MU_ONE;
        else v = ramp20(-40 * SCALE - x);
      end
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### hdl/fos_in_if.sv
interface fos_in_if;
  import fos_pkg::*;

  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] front_distance;
  logic [DIST_W-1:0] right_distance;
  logic [DIST_W-1:0] left_distance;
  logic [DIST_W-1:0] rear_distance;

  modport source (
    output valid, front_distance, right_distance, left_distance, rear_distance,
    input  ready
  );

  modport sink (
    input  valid, front_distance, right_distance, left_distance, rear_distance,
    output ready
  );
endinterface

### hdl/fos_out_if.sv
interface fos_out_if;
  import fos_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [STEER_W-1:0] steering_value;
  logic [DIR_W-1:0]          direction_code;
  logic                      no_activation;

  modport source (
    output valid, steering_value, direction_code, no_activation,
    input  ready
  );

  modport sink (
    input  valid, steering_value, direction_code, no_activation,
    output ready
  );
endinterface

### hdl/fos_ramp_div.sv
module fos_ramp_div (
  input  logic                                 clk,
  input  logic                                 adv,
  input  logic [fos_pkg::SPAN_W-1:0]           off,
  input  logic [fos_pkg::SPAN_W-1:0]           span,
  output logic [fos_pkg::MEMBERSHIP_BITS-1:0]  quot
);
  import fos_pkg::*;

  localparam int STAGES = MEMBERSHIP_BITS;

  logic [SPAN_W-1:0] rem_r  [STAGES];
  logic [SPAN_W-1:0] span_r [STAGES];
  logic [STAGES-1:0] q_r    [STAGES];

  // One quotient bit per stage: double the remainder, subtract the span if it fits
  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [SPAN_W-1:0] rin;
    logic [SPAN_W-1:0] sin;
    logic [STAGES-1:0] qin;
    logic [SPAN_W:0]   dbl;
    logic              take;

    if (s == 0) begin : g_first
      assign rin = off;
      assign sin = span;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_r[s-1];
      assign sin = span_r[s-1];
      assign qin = q_r[s-1];
    end

    assign dbl  = {rin, 1'b0};
    assign take = (dbl >= {1'b0, sin});

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s]  <= take ? SPAN_W'(dbl - {1'b0, sin}) : SPAN_W'(dbl);
        span_r[s] <= sin;
        q_r[s]    <= {qin[STAGES-2:0], take};
      end
    end
  end

  assign quot = q_r[STAGES-1];

endmodule

### hdl/fos_fuzzify.sv
module fos_fuzzify (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            adv,
  input  logic                                            in_vld,
  input  logic [fos_pkg::LIMIT_W-1:0]                     limit,
  input  logic [fos_pkg::NUM_DIST-1:0][fos_pkg::DIST_W-1:0] range_cm,
  output logic                                            out_vld,
  output fos_pkg::dist_mu_t [fos_pkg::NUM_DIST-1:0]       mu
);
  import fos_pkg::*;

  localparam int LAT = MEMBERSHIP_BITS + 1;
  localparam int XW  = DIST_W + 4;

  typedef enum logic [1:0] {SEL_ZERO, SEL_FULL, SEL_RAMP} sel_t;

  typedef struct packed {
    sel_t near_s;
    sel_t med_s;
    sel_t far_s;
  } dsel_t;

  function automatic mu_t pick(sel_t s, logic [MEMBERSHIP_BITS-1:0] q);
    mu_t v;
    case (s)
      SEL_FULL: v = MU_ONE;
      SEL_RAMP: v = {1'b0, q};
      default:  v = '0;
    endcase
    return v;
  endfunction

  logic [SPAN_W-1:0] l1, l2, l3, l4, l5, l6, l8;
  logic              vld_r [LAT];

  // Corner multiples of the corridor limit
  assign l1 = SPAN_W'(limit);
  assign l2 = l1 << 1;
  assign l3 = l2 + l1;
  assign l4 = l1 << 2;
  assign l5 = l4 + l1;
  assign l6 = l4 + l2;
  assign l8 = l1 << 3;

  for (genvar k = 0; k < NUM_DIST; k++) begin : g_dist
    logic [XW-1:0] x, e2, e4, e5, e6, e8;
    logic          le2, ge5, ge8, lt4, le6, le5, lt8;
    dsel_t         sel;
    dsel_t         sel_r [MEMBERSHIP_BITS];
    logic [SPAN_W-1:0] off_n, off_m, off_f;
    logic [MEMBERSHIP_BITS-1:0] q_n, q_m, q_f;
    dist_mu_t      mu_r;

    // Distance times ten against the scaled corners
    assign x  = (XW'(range_cm[k]) << 3) + (XW'(range_cm[k]) << 1);
    assign e2 = XW'(l2);
    assign e4 = XW'(l4);
    assign e5 = XW'(l5);
    assign e6 = XW'(l6);
    assign e8 = XW'(l8);

    assign le2 = (x <= e2);
    assign lt4 = (x < e4);
    assign le5 = (x <= e5);
    assign ge5 = (x >= e5);
    assign le6 = (x <= e6);
    assign lt8 = (x < e8);
    assign ge8 = (x >= e8);

    assign sel.near_s = (x == '0) ? SEL_ZERO : le2 ? SEL_FULL : ge5 ? SEL_ZERO : SEL_RAMP;
    assign sel.med_s  = (le2 || ge8) ? SEL_ZERO : lt4 ? SEL_RAMP : le6 ? SEL_FULL : SEL_RAMP;
    assign sel.far_s  = le5 ? SEL_ZERO : lt8 ? SEL_RAMP : SEL_FULL;

    assign off_n = SPAN_W'(e5 - x);
    assign off_m = lt4 ? SPAN_W'(x - e2) : SPAN_W'(e8 - x);
    assign off_f = SPAN_W'(x - e5);

    fos_ramp_div u_div_near (.clk(clk), .adv(adv), .off(off_n), .span(l3), .quot(q_n));
    fos_ramp_div u_div_med  (.clk(clk), .adv(adv), .off(off_m), .span(l2), .quot(q_m));
    fos_ramp_div u_div_far  (.clk(clk), .adv(adv), .off(off_f), .span(l3), .quot(q_f));

    // Carry the region selects alongside the dividers, then merge
    always_ff @(posedge clk) begin
      if (adv) begin
        sel_r[0] <= sel;
        for (int j = 1; j < MEMBERSHIP_BITS; j++) begin
          sel_r[j] <= sel_r[j-1];
        end
        mu_r.near_mu <= pick(sel_r[MEMBERSHIP_BITS-1].near_s, q_n);
        mu_r.med_mu  <= pick(sel_r[MEMBERSHIP_BITS-1].med_s, q_m);
        mu_r.far_mu  <= pick(sel_r[MEMBERSHIP_BITS-1].far_s, q_f);
      end
    end

    assign mu[k] = mu_r;
  end

  // Advance the valid line with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < LAT; j++) vld_r[j] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
      for (int j = 1; j < LAT; j++) vld_r[j] <= vld_r[j-1];
    end
  end

  assign out_vld = vld_r[LAT-1];

endmodule

### hdl/fos_rules.sv
module fos_rules (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      adv,
  input  logic                                      in_vld,
  input  fos_pkg::dist_mu_t [fos_pkg::NUM_DIST-1:0] mu,
  output logic                                      out_vld,
  output fos_pkg::pref_t                            pref
);
  import fos_pkg::*;

  localparam int VW    = MUW + 2;
  localparam int MW    = MEMBERSHIP_BITS + 4;
  localparam int PW    = VW + MW;
  localparam int SHIFT = MEMBERSHIP_BITS + 6;
  localparam logic [MW-1:0] RECIP10 = MW'(((longint'(1) << SHIFT) + 9) / 10);

  function automatic mu_t mn3(mu_t a, mu_t b, mu_t c);
    return mu_min(a, mu_min(b, c));
  endfunction

  dist_mu_t f, r, l, b;
  mu_t      ps_m, pr_m, pl_m, a1, a2, a3;

  mu_t      ps1_r, pr1_r, pl1_r, pb1_r, a1_r, a2_r, a3_r;
  mu_t      ps2_r, pr2_r, pl2_r, pb2_r, a1h_r, a2h_r;
  logic [PW-1:0] p1_r, p2_r, p3_r, p6_r;
  pref_t    pref_r;
  logic     vld_r [3];

  assign f = mu[0];
  assign r = mu[1];
  assign l = mu[2];
  assign b = mu[3];

  // Rule strengths before weighting
  assign ps_m = mu_max(mu_max(mu_max(mn3(f.far_mu, r.near_mu, l.near_mu),
                                     mn3(f.far_mu, l.med_mu, r.med_mu)),
                              mu_max(mn3(f.med_mu, l.med_mu, r.med_mu),
                                     mn3(f.med_mu, l.near_mu, b.near_mu))),
                       mu_max(mu_max(mn3(f.med_mu, r.near_mu, b.near_mu),
                                     mu_min(b.near_mu, f.far_mu)),
                              mu_max(mu_min(mu_min(f.med_mu, l.med_mu),
                                            mu_min(r.med_mu, b.med_mu)),
                                     mn3(f.med_mu, l.near_mu, r.near_mu))));
  assign pr_m = mu_max(mu_max(mn3(r.far_mu, f.near_mu, l.near_mu),
                              mn3(r.med_mu, f.near_mu, l.near_mu)),
                       mu_max(mn3(f.near_mu, l.med_mu, r.far_mu),
                              mn3(f.near_mu, l.far_mu, r.far_mu)));
  assign pl_m = mu_max(mu_max(mn3(l.far_mu, f.near_mu, r.near_mu),
                              mn3(l.med_mu, f.near_mu, r.near_mu)),
                       mn3(f.near_mu, r.med_mu, l.far_mu));
  assign a1 = mn3(l.near_mu, f.far_mu, r.med_mu);
  assign a2 = mn3(r.near_mu, f.far_mu, l.med_mu);
  assign a3 = mn3(f.far_mu, l.far_mu, r.far_mu);

  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage 1: min/max terms
      ps1_r <= ps_m;
      pr1_r <= pr_m;
      pl1_r <= pl_m;
      pb1_r <= mn3(f.near_mu, r.near_mu, l.near_mu);
      a1_r  <= a1;
      a2_r  <= a2;
      a3_r  <= a3;
      // Stage 2: weights, tenths by reciprocal multiply
      ps2_r <= ps1_r;
      pr2_r <= pr1_r;
      pl2_r <= pl1_r;
      pb2_r <= pb1_r;
      a1h_r <= a1_r >> 1;
      a2h_r <= a2_r >> 1;
      p1_r  <= PW'(VW'(a1_r) * VW'(3)) * PW'(RECIP10);
      p2_r  <= PW'(VW'(a2_r) * VW'(3)) * PW'(RECIP10);
      p3_r  <= PW'(VW'(a3_r) * VW'(3)) * PW'(RECIP10);
      p6_r  <= PW'(VW'(a3_r) * VW'(6)) * PW'(RECIP10);
      // Stage 3: final maxima
      pref_r.straight_p <= mu_max(mu_max(ps2_r, MUW'(p1_r >> SHIFT)),
                                  mu_max(MUW'(p2_r >> SHIFT), MUW'(p6_r >> SHIFT)));
      pref_r.right_p    <= mu_max(pr2_r, mu_max(a1h_r, MUW'(p3_r >> SHIFT)));
      pref_r.left_p     <= mu_max(pl2_r, a2h_r);
      pref_r.back_p     <= pb2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < 3; j++) vld_r[j] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
      vld_r[1] <= vld_r[0];
      vld_r[2] <= vld_r[1];
    end
  end

  assign pref    = pref_r;
  assign out_vld = vld_r[2];

endmodule

### hdl/fos_centroid.sv
module fos_centroid (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_vld,
  input  fos_pkg::pref_t   pref,
  output logic             out_vld,
  output fos_pkg::result_t res
);
  import fos_pkg::*;

  localparam int N      = UNIVERSE_POINTS;
  localparam int LEVELS = $clog2(N);
  localparam int LEAVES = 2 ** LEVELS;
  localparam int NODES  = 2 * LEAVES - 1;
  localparam int XW     = $clog2(100 * SCALE + 1) + 1;
  localparam int PRODW  = XW + MUW;
  localparam int NUMW   = PRODW + LEVELS;
  localparam int DENW   = MUW + LEVELS;
  localparam int DW     = DENW + $clog2(SCALE + 1);
  localparam int MAGW   = NUMW + STEER_FRAC;
  localparam int QW     = $clog2(STEER_MAX + 1);
  localparam int RW     = ((MAGW + 1) > (DW + QW)) ? (MAGW + 1) : (DW + QW);
  localparam int VLAT   = LEVELS + QW + 5;

  mu_t                    c_r   [N];
  logic signed [NUMW-1:0] num_r [NODES];
  logic [DENW-1:0]        den_r [NODES];

  logic [DW-1:0]   d0_r;
  logic [NUMW-1:0] absn_r;
  logic            neg0_r, none0_r;

  logic [RW-1:0]   rem_r  [QW+1];
  logic [DW-1:0]   dv_r   [QW+1];
  logic [QW-1:0]   q_r    [QW+1];
  logic            neg_r  [QW+1];
  logic            none_r [QW+1];

  logic [QW-1:0]            q_clamp;
  logic signed [STEER_W-1:0] steer;
  result_t                  res_r;
  logic                     vld_r [VLAT];

  // Lanes: clipped set membership, then signed moment at each point
  for (genvar i = 0; i < N; i++) begin : g_lane
    localparam mu_t TL = out_set_mu(SET_LEFT, i);
    localparam mu_t TS = out_set_mu(SET_STRAIGHT, i);
    localparam mu_t TR = out_set_mu(SET_RIGHT, i);
    localparam mu_t TB = out_set_mu(SET_BACK, i);
    localparam logic signed [XW-1:0] XI = XW'(univ_x(i));
    logic signed [PRODW:0] prod;

    assign prod = XI * $signed({1'b0, c_r[i]});

    always_ff @(posedge clk) begin
      if (adv) begin
        c_r[i] <= mu_max(mu_max(mu_min(pref.left_p, TL), mu_min(pref.straight_p, TS)),
                         mu_max(mu_min(pref.right_p, TR), mu_min(pref.back_p, TB)));
        num_r[LEAVES-1+i] <= NUMW'(prod);
        den_r[LEAVES-1+i] <= DENW'(c_r[i]);
      end
    end
  end

  // Pad the unused leaves with zero
  for (genvar i = N; i < LEAVES; i++) begin : g_pad
    always_ff @(posedge clk) begin
      if (adv) begin
        num_r[LEAVES-1+i] <= '0;
        den_r[LEAVES-1+i] <= '0;
      end
    end
  end

  // Registered adder tree, one level per cycle
  for (genvar k = 0; k < LEAVES - 1; k++) begin : g_node
    always_ff @(posedge clk) begin
      if (adv) begin
        num_r[k] <= num_r[2*k+1] + num_r[2*k+2];
        den_r[k] <= den_r[2*k+1] + den_r[2*k+2];
      end
    end
  end

  // Scale the denominator, take the magnitude, then round and divide
  always_ff @(posedge clk) begin
    if (adv) begin
      d0_r    <= DW'(den_r[0]) * DW'(SCALE);
      neg0_r  <= num_r[0][NUMW-1];
      absn_r  <= num_r[0][NUMW-1] ? NUMW'(-num_r[0]) : NUMW'(num_r[0]);
      none0_r <= (den_r[0] == '0);

      rem_r[0]  <= RW'({absn_r, {STEER_FRAC{1'b0}}}) + RW'(d0_r >> 1);
      dv_r[0]   <= d0_r;
      q_r[0]    <= '0;
      neg_r[0]  <= neg0_r;
      none_r[0] <= none0_r;
    end
  end

  // Restoring divider, one quotient bit per stage, MSB first
  for (genvar j = 1; j <= QW; j++) begin : g_div
    logic [RW-1:0] sh;
    logic          take;

    assign sh   = RW'(dv_r[j-1]) << (QW - j);
    assign take = (rem_r[j-1] >= sh);

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[j]  <= take ? (rem_r[j-1] - sh) : rem_r[j-1];
        dv_r[j]   <= dv_r[j-1];
        q_r[j]    <= {q_r[j-1][QW-2:0], take};
        neg_r[j]  <= neg_r[j-1];
        none_r[j] <= none_r[j-1];
      end
    end
  end

  // Clamp, sign and classify
  assign q_clamp = (q_r[QW] > QW'(STEER_MAX)) ? QW'(STEER_MAX) : q_r[QW];
  assign steer   = neg_r[QW] ? -STEER_W'(q_clamp) : STEER_W'(q_clamp);

  always_ff @(posedge clk) begin
    if (adv) begin
      if (none_r[QW]) begin
        res_r.steering_value <= '0;
        res_r.direction_code <= DIR_FWD;
        res_r.no_activation  <= 1'b1;
      end else begin
        res_r.steering_value <= steer;
        res_r.no_activation  <= 1'b0;
        if (steer < STEER_W'(BACK_LIM))       res_r.direction_code <= DIR_BACK;
        else if (steer < STEER_W'(LEFT_LIM))  res_r.direction_code <= DIR_LEFT;
        else if (steer > STEER_W'(RIGHT_LIM)) res_r.direction_code <= DIR_RIGHT;
        else                                  res_r.direction_code <= DIR_FWD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < VLAT; j++) vld_r[j] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_vld;
      for (int j = 1; j < VLAT; j++) vld_r[j] <= vld_r[j-1];
    end
  end

  assign res     = res_r;
  assign out_vld = vld_r[VLAT-1];

  a_steer_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld |-> (res_r.steering_value <= STEER_W'(STEER_MAX)) &&
                (res_r.steering_value >= -STEER_W'(STEER_MAX)))
    else $error("steering value beyond full scale");

  a_back_class: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && res_r.direction_code == DIR_BACK |->
      res_r.steering_value < STEER_W'(BACK_LIM))
    else $error("back direction with steering above back limit");

endmodule

### hdl/fuzzy_obstacle_steering_top.sv
// Fuzzy obstacle steering.
// Input channel in_ch carries one beat of four range readings (front, right,
// left, rear, 9 bit cm, 0 means no echo). Output channel out_ch returns one
// beat per input: signed steering value in 1/128 units, a direction code and
// a no-activation flag. Both channels use valid/ready; a beat moves when
// both are high.
// The corridor limit is written over the APB port at byte address 0 and
// reads back there; the user must write it only while the block is idle,
// which the block itself does not enforce. Throughput: one beat per cycle
// while in_ch.ready is high. A beat passes the membership dividers
// (16 stages), the rule stages (3), the 64-leaf adder tree (6 levels),
// the 14-stage centroid divider and the lane, scaling, rounding, classify
// and output registers. Reset clears all valid bits and loads a corridor
// limit of 25; the pipeline payload is not cleared.
// When the receiver stalls, a finished beat waits in the output register and
// the next one in a skid register; only then does in_ch.ready drop and the
// whole pipeline hold.
module fuzzy_obstacle_steering_top (
  input  logic                         clk,
  input  logic                         rst_n,
  fos_in_if.sink                       in_ch,
  fos_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fos_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import fos_pkg::*;

  logic [LIMIT_W-1:0]                 limit_r;
  logic                               adv;
  logic [NUM_DIST-1:0][DIST_W-1:0]    range_cm;
  logic                               fz_vld, rl_vld, ct_vld;
  dist_mu_t [NUM_DIST-1:0]            mu;
  pref_t                              pref;
  result_t                            res;
  result_t                            out_r, skid_r;
  logic                               out_vld_r, skid_vld_r;
  logic                               hit;

  // Configuration register
  assign pready = 1'b1;
  assign hit    = (paddr[CFG_AW-1:2] == REG_CORRIDOR_LIMIT);
  assign prdata = hit ? 32'(limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && hit) begin
      limit_r <= pwdata[LIMIT_W-1:0];
    end
  end

  // Pipeline moves whenever the skid register is free
  assign adv         = !skid_vld_r;
  assign in_ch.ready = adv;
  assign range_cm    = {in_ch.rear_distance, in_ch.left_distance,
                        in_ch.right_distance, in_ch.front_distance};

  fos_fuzzify u_fuzzify (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_vld(in_ch.valid && in_ch.ready),
    .limit(limit_r), .range_cm(range_cm),
    .out_vld(fz_vld), .mu(mu)
  );

  fos_rules u_rules (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_vld(fz_vld), .mu(mu),
    .out_vld(rl_vld), .pref(pref)
  );

  fos_centroid u_centroid (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_vld(rl_vld), .pref(pref),
    .out_vld(ct_vld), .res(res)
  );

  // Output register with skid: park a beat when the receiver holds off
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (adv && ct_vld) begin
      if (!out_vld_r || out_ch.ready) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (out_vld_r && out_ch.ready) begin
      out_vld_r  <= skid_vld_r;
      skid_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ct_vld) begin
      if (!out_vld_r || out_ch.ready) out_r <= res;
      else skid_r <= res;
    end else if (out_vld_r && out_ch.ready && skid_vld_r) begin
      out_r <= skid_r;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.steering_value = out_r.steering_value;
  assign out_ch.direction_code = out_r.direction_code;
  assign out_ch.no_activation  = out_r.no_activation;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid holds a beat while output register is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_vld_r) |-> $past(out_vld_r && !out_ch.ready))
    else $error("skid filled without a stalled output");

  a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.no_activation |->
      out_r.steering_value == '0 && out_r.direction_code == DIR_FWD)
    else $error("no-activation beat with nonzero steering");

endmodule

### bench/fuzzy_obstacle_steering_top_test.sv
module fuzzy_obstacle_steering_top_test;
  import fos_pkg::*;

  localparam int LATENCY    = 46;
  localparam int STALL_LIMIT = 20000;
  localparam int RANDOM_BEATS = 1750;

  typedef struct {
    logic [DIST_W-1:0] front;
    logic [DIST_W-1:0] right;
    logic [DIST_W-1:0] left;
    logic [DIST_W-1:0] rear;
  } ranges_t;

  typedef struct {
    logic signed [STEER_W-1:0] steer;
    logic [DIR_W-1:0]          dir;
    logic                      idle_set;
  } steer_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  fos_in_if  in_ch ();
  fos_out_if out_ch ();

  fuzzy_obstacle_steering_top i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  ranges_t pending_ranges[$];
  steer_t  expected_steer[$];
  int      limit_cm;
  int      mismatches;
  int      quiet_cycles;
  bit      send_enable;
  bit      in_acc;
  int      burst_left, gap_left;
  int      stall_phase;

  // Fuzzify one reading against the corridor limit
  function automatic void fuzzify_range(input int raw, input int lim,
                                        output longint nr, output longint md,
                                        output longint fr);
    longint x, l, one;
    x = raw * 10;
    l = lim;
    one = longint'(1) << MEMBERSHIP_BITS;
    if (x == 0) nr = 0;
    else if (x <= 2 * l) nr = one;
    else if (x >= 5 * l) nr = 0;
    else nr = ((5 * l - x) * one) / (3 * l);
    if (x <= 2 * l || x >= 8 * l) md = 0;
    else if (x < 4 * l) md = ((x - 2 * l) * one) / (2 * l);
    else if (x <= 6 * l) md = one;
    else md = ((8 * l - x) * one) / (2 * l);
    if (x == 0) fr = 0;
    else if (x <= 5 * l) fr = 0;
    else if (x < 8 * l) fr = ((x - 5 * l) * one) / (3 * l);
    else fr = one;
  endfunction

  function automatic longint trapezoid(longint x, longint a, longint b,
                                       longint c, longint d);
    longint one;
    one = longint'(1) << MEMBERSHIP_BITS;
    if (x <= a || x >= d) return 0;
    if (x < b) return ((x - a) * one) / (b - a);
    if (x <= c) return one;
    return ((d - x) * one) / (d - c);
  endfunction

  function automatic longint lo3(longint a, longint b, longint c);
    longint m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic longint hi(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  // Rules, clipping and centroid for one set of readings
  function automatic steer_t predict_steering(ranges_t r, int lim);
    longint fn, fm, ff, rn, rm, rf, ln, lm, lf, bn, bm, bf;
    longint pl, ps, pr, pb, a, x, c, s, den, d, mag, q;
    longint num, st;
    steer_t res;
    fuzzify_range(r.front, lim, fn, fm, ff);
    fuzzify_range(r.right, lim, rn, rm, rf);
    fuzzify_range(r.left, lim, ln, lm, lf);
    fuzzify_range(r.rear, lim, bn, bm, bf);
    pl = 0; ps = 0; pr = 0; pb = 0;
    ps = hi(ps, lo3(ff, rn, ln));
    pr = hi(pr, lo3(rf, fn, ln));
    pl = hi(pl, lo3(lf, fn, rn));
    pb = hi(pb, lo3(fn, rn, ln));
    ps = hi(ps, lo3(ff, lm, rm));
    ps = hi(ps, lo3(fm, lm, rm));
    pl = hi(pl, lo3(lm, fn, rn));
    pr = hi(pr, lo3(rm, fn, ln));
    ps = hi(ps, lo3(fm, ln, bn));
    ps = hi(ps, lo3(fm, rn, bn));
    ps = hi(ps, lo3(bn, ff, ff));
    ps = hi(ps, lo3(lo3(fm, lm, lm), rm, bm));
    ps = hi(ps, lo3(fm, ln, rn));
    a = lo3(ln, ff, rm);
    pr = hi(pr, a / 2);
    ps = hi(ps, (a * 3) / 10);
    a = lo3(rn, ff, lm);
    pl = hi(pl, a / 2);
    ps = hi(ps, (a * 3) / 10);
    pr = hi(pr, lo3(fn, lm, rf));
    pl = hi(pl, lo3(fn, rm, lf));
    pr = hi(pr, lo3(fn, lf, rf));
    a = lo3(ff, lf, rf);
    ps = hi(ps, (a * 6) / 10);
    pr = hi(pr, (a * 3) / 10);
    s = UNIVERSE_POINTS - 1;
    num = 0; den = 0;
    for (int i = 0; i < UNIVERSE_POINTS; i++) begin
      x = -100 * s + 200 * i;
      c = lo3(pl, trapezoid(x, -80 * s, -60 * s, -40 * s, -10 * s), pl);
      c = hi(c, lo3(ps, trapezoid(x, -30 * s, -10 * s, 10 * s, 30 * s), ps));
      c = hi(c, lo3(pr, trapezoid(x, 10 * s, 40 * s, 60 * s, 80 * s), pr));
      c = hi(c, lo3(pb, trapezoid(x, -100 * s, -80 * s, -60 * s, -40 * s), pb));
      num += x * c;
      den += c;
    end
    res.idle_set = 1'b0;
    res.dir = DIR_FWD;
    st = 0;
    if (den == 0) begin
      res.idle_set = 1'b1;
    end else begin
      d = den * s;
      mag = ((num < 0) ? -num : num) * 128;
      q = (mag + d / 2) / d;
      if (q > STEER_MAX) q = STEER_MAX;
      st = (num < 0) ? -q : q;
      if (st < BACK_LIM) res.dir = DIR_BACK;
      else if (st < LEFT_LIM) res.dir = DIR_LEFT;
      else if (st > RIGHT_LIM) res.dir = DIR_RIGHT;
      else res.dir = DIR_FWD;
    end
    res.steer = st[STEER_W-1:0];
    return res;
  endfunction

  function automatic int pick_range(int lim);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return $urandom_range(0, 511);
    if (sel == 1) return 0;
    return $urandom_range(1, (lim * 9) / 10 + 1);
  endfunction

  task automatic queue_beat(int f, int r, int l, int b);
    ranges_t it;
    it.front = DIST_W'(f); it.right = DIST_W'(r);
    it.left = DIST_W'(l); it.rear = DIST_W'(b);
    pending_ranges.push_back(it);
  endtask

  task automatic wait_drained();
    while (pending_ranges.size() != 0 || in_ch.valid || expected_steer.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // Two-phase register write, changes at the falling edge
  task automatic write_limit(int value);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {REG_CORRIDOR_LIMIT, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    limit_cm = value;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Note an input beat taken at the rising edge
  always @(posedge clk) begin
    in_acc <= in_ch.valid && in_ch.ready;
  end

  // Sender: bursts and gaps, updated at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_acc) begin
      if (in_acc) void'(pending_ranges.pop_front());
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (send_enable && pending_ranges.size() > 0) begin
        ranges_t nx;
        nx = pending_ranges[0];
        in_ch.valid <= 1'b1;
        in_ch.front_distance <= nx.front;
        in_ch.right_distance <= nx.right;
        in_ch.left_distance <= nx.left;
        in_ch.rear_distance <= nx.rear;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 30);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: stalls on its own rolling pattern
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase[9:8] == 2'b00) out_ch.ready <= 1'b1;
    else if (stall_phase[9:8] == 2'b01) out_ch.ready <= ($urandom_range(0, 9) != 0);
    else out_ch.ready <= ($urandom_range(0, 2) == 0);
  end

  // Prediction on accepted input beats, checking on result beats
  always @(posedge clk) begin
    if (rst_n) begin
      steer_t got, want;
      ranges_t acc;
      bit moved;
      moved = (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready);
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (in_ch.valid && in_ch.ready) begin
        acc.front = in_ch.front_distance;
        acc.right = in_ch.right_distance;
        acc.left = in_ch.left_distance;
        acc.rear = in_ch.rear_distance;
        expected_steer.push_back(predict_steering(acc, limit_cm));
      end
      if (out_ch.valid && out_ch.ready) begin
        got.steer = out_ch.steering_value;
        got.dir = out_ch.direction_code;
        got.idle_set = out_ch.no_activation;
        if (expected_steer.size() == 0) begin
          $error("result beat with nothing expected");
          mismatches++;
        end else begin
          want = expected_steer.pop_front();
          if (got.steer !== want.steer) begin
            $error("steering_value expected %0d got %0d", want.steer, got.steer);
            mismatches++;
          end
          if (got.dir !== want.dir) begin
            $error("direction_code expected %0d got %0d", want.dir, got.dir);
            mismatches++;
          end
          if (got.idle_set !== want.idle_set) begin
            $error("no_activation expected %0d got %0d", want.idle_set, got.idle_set);
            mismatches++;
          end
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    int limits[6];
    int l, f;
    limits = '{1, 255, 25, 10, 100, 60};
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.front_distance = '0; in_ch.right_distance = '0;
    in_ch.left_distance = '0; in_ch.rear_distance = '0;
    out_ch.ready = 1'b1;
    limit_cm = LIMIT_RESET;
    mismatches = 0; quiet_cycles = 0; send_enable = 1'b1;
    burst_left = 0; gap_left = 0; stall_phase = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: no echo, extremes, far at limit, typical obstacle layouts
    queue_beat(0, 0, 0, 0);
    queue_beat(511, 511, 511, 511);
    queue_beat(3, 3, 3, 3);
    queue_beat(25, 25, 25, 25);
    queue_beat(20, 3, 3, 3);
    queue_beat(3, 20, 3, 3);
    queue_beat(3, 3, 20, 3);
    queue_beat(12, 12, 12, 12);
    queue_beat(20, 3, 12, 3);
    queue_beat(20, 12, 3, 3);
    queue_beat(3, 12, 20, 1);
    queue_beat(3, 20, 12, 1);
    queue_beat(8, 14, 17, 6);
    queue_beat(256, 128, 1, 0);
    wait_drained();
    // Zero limit: every nonzero reading is far
    write_limit(0);
    queue_beat(1, 1, 1, 1);
    queue_beat(0, 511, 1, 0);
    wait_drained();

    // Random phases over several limits, extremes included
    for (int p = 0; p < 6; p++) begin
      write_limit(limits[p]);
      l = limits[p];
      for (int n = 0; n < RANDOM_BEATS / 6; n++) begin
        f = pick_range(l);
        queue_beat(f, pick_range(l), pick_range(l), pick_range(l));
        if (n == 100 && p == 2) begin
          // let part of the queue go, then hold off until the pipe is empty
          while (pending_ranges.size() > 40) @(posedge clk);
          send_enable = 1'b0;
          while (expected_steer.size() != 0 || in_ch.valid) @(posedge clk);
          send_enable = 1'b1;
        end
      end
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

### sim.f
hdl/fos_pkg.sv
hdl/fos_in_if.sv
hdl/fos_out_if.sv
hdl/fos_ramp_div.sv
hdl/fos_fuzzify.sv
hdl/fos_rules.sv
hdl/fos_centroid.sv
hdl/fuzzy_obstacle_steering_top.sv
bench/fuzzy_obstacle_steering_top_test.sv
